### sv/rme_pkg.sv
// Package for the modular exponentiation block: word widths, types,
// register indexes, command codes and reset values of the registers.
// Used by every other file of the block; depends on nothing.
package rme_pkg;

    // Working width of the arithmetic (8 to 32); the port fields stay 32 bits.
    localparam int WORD_WIDTH = 32;
    localparam int FIELD_W    = 32;
    localparam int DWORD_W    = 2 * WORD_WIDTH;
    localparam int CNT_W      = $clog2(DWORD_W + 1);
    localparam int REG_IDX_W  = 2;

    typedef logic [WORD_WIDTH-1:0] t_word;
    typedef logic [DWORD_W-1:0]    t_dword;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [REG_IDX_W-1:0]  t_reg_idx;

    localparam t_reg_idx REG_MODULUS     = t_reg_idx'(0);
    localparam t_reg_idx REG_PUBLIC_EXP  = t_reg_idx'(1);
    localparam t_reg_idx REG_PRIVATE_EXP = t_reg_idx'(2);

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam t_word MODULUS_RST     = t_word'(3233);
    localparam t_word PUBLIC_EXP_RST  = t_word'(17);
    localparam t_word PRIVATE_EXP_RST = t_word'(2753);
    localparam t_word WORD_ONE        = t_word'(1);

    // Request to the shared modular multiplier.
    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
        t_word modulus;
    } t_mm_req;

    // Response of the shared modular multiplier.
    typedef struct packed {
        logic  done;
        t_word result;
    } t_mm_rsp;

endpackage

### sv/rme_if.sv
// Handshake interfaces of the modular exponentiation block: input items,
// result items and configuration writes. Depends on rme_pkg.
interface rme_in_if
    import rme_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [FIELD_W-1:0]   message;

    modport source (output valid, output command, output message, input ready);
    modport sink   (input valid, input command, input message, output ready);
endinterface

interface rme_out_if
    import rme_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [FIELD_W-1:0]   result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

interface rme_cfg_if
    import rme_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [FIELD_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/rme_modmul.sv
// Shared modular multiplier: one registered full-width product, then,
// for a nonzero modulus, a bit-serial restoring reduction, one quotient
// bit per cycle. Depends on rme_pkg.
module rme_modmul
    import rme_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_mm_req i_req,
    output t_mm_rsp o_rsp
);

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_MUL  = 4'b0010,
        M_PREP = 4'b0100,
        M_RED  = 4'b1000
    } t_mm_state;

    t_mm_state r_state, n_state;
    logic      r_done, n_done;
    t_cnt      r_cnt, n_cnt;
    t_word     r_a, n_a;
    t_word     r_b, n_b;
    t_dword    r_prod, n_prod;
    t_word     r_rem, n_rem;

    logic [WORD_WIDTH:0] trial;
    logic [WORD_WIDTH:0] diff;

    assign trial = {r_rem, r_prod[DWORD_W-1]};
    assign diff  = trial - {1'b0, i_req.modulus};

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_a     = r_a;
        n_b     = r_b;
        n_prod  = r_prod;
        n_rem   = r_rem;
        unique case (r_state)
            M_IDLE: begin
                if (i_req.start) begin
                    n_a     = i_req.a;
                    n_b     = i_req.b;
                    n_state = M_MUL;
                end
            end
            M_MUL: begin
                n_prod  = t_dword'(r_a) * t_dword'(r_b);
                n_state = M_PREP;
            end
            M_PREP: begin
                if (i_req.modulus == '0) begin
                    // No reduction: the product wraps to the word width.
                    n_rem   = r_prod[WORD_WIDTH-1:0];
                    n_done  = 1'b1;
                    n_state = M_IDLE;
                end else if (r_prod[DWORD_W-1:WORD_WIDTH] < i_req.modulus) begin
                    // The upper half is already a valid partial remainder.
                    n_rem   = r_prod[DWORD_W-1:WORD_WIDTH];
                    n_prod  = {r_prod[WORD_WIDTH-1:0], {WORD_WIDTH{1'b0}}};
                    n_cnt   = t_cnt'(WORD_WIDTH);
                    n_state = M_RED;
                end else begin
                    n_rem   = '0;
                    n_cnt   = t_cnt'(DWORD_W);
                    n_state = M_RED;
                end
            end
            M_RED: begin
                if (trial >= {1'b0, i_req.modulus}) begin
                    n_rem = diff[WORD_WIDTH-1:0];
                end else begin
                    n_rem = trial[WORD_WIDTH-1:0];
                end
                n_prod = {r_prod[DWORD_W-2:0], 1'b0};
                n_cnt  = r_cnt - t_cnt'(1);
                if (r_cnt == t_cnt'(1)) begin
                    n_done  = 1'b1;
                    n_state = M_IDLE;
                end
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
        r_a    <= n_a;
        r_b    <= n_b;
        r_prod <= n_prod;
        r_rem  <= n_rem;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_rem;

endmodule

### sv/rsa_modular_exponentiation_top.sv
// Top level of the modular exponentiation block: configuration registers,
// the square-and-multiply sequencer and the shared modular multiplier.
// Depends on rme_pkg, the interfaces in rme_if and rme_modmul.
//
// This block raises each message item to the public exponent (command 0) or
// the private exponent (command 1), modulo the configured modulus, and
// returns one result item per input item. The exponent is scanned from its
// least significant bit upward: the accumulator starts at one, is multiplied
// by the running base whenever the current bit is set, and the base is
// squared while higher exponent bits remain. An exponent of zero returns one,
// unreduced, and a modulus of zero makes every product wrap to the word width.
// All multiplications share one modular multiplier, which forms the full
// double-width product, registered, and then, for a nonzero modulus, reduces
// it one bit per cycle. The reduction is longest when the upper half of the
// product is not below the modulus, which only the first squaring of a large
// message can cause, and it is skipped with a zero modulus. Each exponent bit
// up to the highest set one costs a pass through the check state and, below
// the highest set bit, a squaring, and each set bit one more multiplication;
// most of the time of an item is spent in the reduction loop of the multiplier.
// The input is not ready from the acceptance of an item until its result has
// been taken.
// Configuration writes are always accepted and must only be made while the
// block is idle; writes to an unused index are ignored.
module rsa_modular_exponentiation_top
    import rme_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    rme_cfg_if.sink   i_cfg,
    rme_in_if.sink    i_in,
    rme_out_if.source o_out
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_WACC  = 5'b00100,
        S_WSQR  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state  r_state, n_state;
    t_word   r_modulus;
    t_word   r_pub_exp;
    t_word   r_priv_exp;
    t_word   r_base, n_base;
    t_word   r_exp, n_exp;
    t_word   r_acc, n_acc;

    t_mm_req mm_req;
    t_mm_rsp mm_rsp;

    // Configuration registers: the port never stalls.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= MODULUS_RST;
            r_pub_exp  <= PUBLIC_EXP_RST;
            r_priv_exp <= PRIVATE_EXP_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MODULUS:     r_modulus  <= i_cfg.data[WORD_WIDTH-1:0];
                REG_PUBLIC_EXP:  r_pub_exp  <= i_cfg.data[WORD_WIDTH-1:0];
                REG_PRIVATE_EXP: r_priv_exp <= i_cfg.data[WORD_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // The multiplier is started when a set exponent bit needs the
    // accumulator update, or when the base must be squared.
    always_comb begin
        mm_req.start   = 1'b0;
        mm_req.a       = r_base;
        mm_req.b       = r_base;
        mm_req.modulus = r_modulus;
        if (r_state == S_CHECK && r_exp != '0) begin
            mm_req.start = 1'b1;
            if (r_exp[0]) begin
                mm_req.a = r_acc;
            end
        end else if (r_state == S_WACC && mm_rsp.done && r_exp[WORD_WIDTH-1:1] != '0) begin
            mm_req.start = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_base  = r_base;
        n_exp   = r_exp;
        n_acc   = r_acc;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_base  = i_in.message[WORD_WIDTH-1:0];
                    n_exp   = (i_in.command == CMD_DECRYPT) ? r_priv_exp : r_pub_exp;
                    n_acc   = WORD_ONE;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_exp == '0) begin
                    n_state = S_OUT;
                end else if (r_exp[0]) begin
                    n_state = S_WACC;
                end else begin
                    n_state = S_WSQR;
                end
            end
            S_WACC: begin
                if (mm_rsp.done) begin
                    n_acc = mm_rsp.result;
                    if (r_exp[WORD_WIDTH-1:1] == '0) begin
                        // Last set bit: the final squaring is not needed.
                        n_exp   = '0;
                        n_state = S_CHECK;
                    end else begin
                        n_state = S_WSQR;
                    end
                end
            end
            S_WSQR: begin
                if (mm_rsp.done) begin
                    n_base  = mm_rsp.result;
                    n_exp   = r_exp >> 1;
                    n_state = S_CHECK;
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_base <= n_base;
        r_exp  <= n_exp;
        r_acc  <= n_acc;
    end

    rme_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .o_rsp   (mm_rsp)
    );

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = (r_state == S_OUT);
    assign o_out.result = FIELD_W'(r_acc);

endmodule

### sv/rme_checker.sv
// Port-level checker for the modular exponentiation block, bound to the
// top level. Depends on rme_pkg and rsa_modular_exponentiation_top.
module rme_checker
    import rme_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [FIELD_W-1:0] i_out_result,
    input logic               i_cfg_ready
);

    // A result item waiting means no new item can be taken.
    a_busy_when_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a result item waits");

    // After an item is accepted the block is busy with it.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an item was accepted");

    // A result item is not repeated: valid drops after it has been taken.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) |=> !i_out_valid)
        else $error("result item repeated");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_result)))
        else $error("stalled result item changed");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration port stalled");

endmodule

bind rsa_modular_exponentiation_top rme_checker u_rme_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_result (o_out.result),
    .i_cfg_ready  (i_cfg.ready)
);
